FILE: sv/trilinear_voxel_interpolator_macros.svh
`ifndef TRILINEAR_VOXEL_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_VOXEL_INTERPOLATOR_MACROS_SVH

// clocked check, switched off while reset is held
`define TVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen
`define TVI_ASSERT_NEVER(lbl, cond, msg) \
  `TVI_ASSERT(lbl, !(cond), msg)

`endif

FILE: sv/tvi_pkg.sv
`timescale 1ns / 1ps

package tvi_pkg;

  localparam int AXIS_MAX  = 32;
  localparam int IDX_W     = $clog2(AXIS_MAX);
  localparam int SIZE_W    = IDX_W + 1;
  localparam int ADDR_W    = 3 * IDX_W;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int INT_W     = COORD_W - FRAC_BITS;
  localparam int W_W       = FRAC_BITS + 1;
  localparam int KXY_W     = 2 * FRAC_BITS + 1;
  localparam int KXYZ_W    = 3 * FRAC_BITS + 1;
  localparam int PROD_W    = KXYZ_W + 1 + SAMPLE_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int PLANE_W   = 2 * IDX_W + 1;
  localparam int CORNERS   = 8;
  localparam int CNT_W     = $clog2(CORNERS);

  localparam logic [W_W-1:0] ONE_W = W_W'(1) << FRAC_BITS;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_INTERP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } tvi_state_e;

  typedef struct packed {
    logic start;
    logic valid;
  } tvi_mac_ctl_t;

  // sizes out of range act as the nearest legal size
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s < SIZE_W'(2)) r = SIZE_W'(2);
    else if (s > SIZE_W'(AXIS_MAX)) r = SIZE_W'(AXIS_MAX);
    else r = s;
    return r;
  endfunction

endpackage

FILE: sv/tvi_axis_split.sv
`timescale 1ns / 1ps

module tvi_axis_split import tvi_pkg::*; (
  input  logic signed [COORD_W-1:0] coord_i,
  input  logic        [SIZE_W-1:0]  size_i,
  output logic        [IDX_W-1:0]   floor_o,
  output logic        [IDX_W-1:0]   near_o,
  output logic        [W_W-1:0]     weight_o
);

  logic [SIZE_W-1:0]    last;
  logic [INT_W-1:0]     f_int;
  logic [FRAC_BITS-1:0] frac;

  assign last  = eff_size(size_i) - SIZE_W'(1);
  assign f_int = coord_i[COORD_W-1:FRAC_BITS];
  assign frac  = coord_i[FRAC_BITS-1:0];

  always_comb begin
    if (f_int[INT_W-1]) begin
      floor_o  = '0;
      near_o   = '0;
      weight_o = '0;
    end else if (INT_W'(f_int) >= INT_W'(last)) begin
      floor_o  = IDX_W'(last - SIZE_W'(1));
      near_o   = IDX_W'(last);
      weight_o = ONE_W;
    end else begin
      // in range the floor stays below last, so it fits the index width
      floor_o  = IDX_W'(f_int);
      near_o   = IDX_W'(f_int) + IDX_W'(frac[FRAC_BITS-1]);
      weight_o = {1'b0, frac};
    end
  end

endmodule

FILE: sv/tvi_voxel_mem.sv
`timescale 1ns / 1ps

module tvi_voxel_mem import tvi_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic signed [SAMPLE_W-1:0] wdata_i,
  output logic signed [SAMPLE_W-1:0] rdata_o
);

  logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tvi_mac.sv
`timescale 1ns / 1ps

module tvi_mac import tvi_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tvi_mac_ctl_t               ctl_i,
  input  logic [W_W-1:0]             kx_i,
  input  logic [W_W-1:0]             ky_i,
  input  logic [W_W-1:0]             kz_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       busy_o,
  output logic signed [SAMPLE_W-1:0] blend_o
);

  logic                       v1_q, v2_q, v3_q;
  logic [KXY_W-1:0]           kxy_q;
  logic [W_W-1:0]             kz_q;
  logic [KXYZ_W-1:0]          kxyz_q;
  logic signed [SAMPLE_W-1:0] samp_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W-1:0]    rounded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // memory data lines up with the first weight stage
  always_ff @(posedge clk_i) begin
    kxy_q  <= KXY_W'(kx_i * ky_i);
    kz_q   <= kz_i;
    kxyz_q <= KXYZ_W'(kxy_q * kz_q);
    if (v1_q) begin
      samp_q <= sample_i;
    end
    prod_q <= PROD_W'($signed({1'b0, kxyz_q}) * samp_q);
    acc_q  <= acc_d;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.start) begin
      acc_d = '0;
    end else if (v3_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then drop the weight scale
  assign rounded = acc_q + (ACC_W'(1) <<< (3 * FRAC_BITS - 1));
  assign blend_o = rounded[3*FRAC_BITS +: SAMPLE_W];
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule

FILE: sv/trilinear_voxel_interpolator.sv
`timescale 1ns / 1ps
// Trilinear voxel interpolator.
// Input stream (s_axis): tuser carries func. func 0 stores voxel_value at
// voxel_addr and gives no output beat; func 1 interpolates at the fixed-point
// coordinate (8 fractional bits per axis) and gives one output beat.
// Output stream (m_axis): floor, near and upper weight per axis plus the
// blended sample, rounded to nearest.
// Configuration: cfg_we_i writes size_x / size_y / size_z (index 0..2) on the
// clock edge; write only while no interpolation is in flight.
// Flow: write beats are taken back to back while idle. An interpolation holds
// the input off from accept until its result is loaded: the eight corner
// voxels are read one per cycle from the single-port voxel memory, then a
// four-stage multiply and accumulate drains.
// The output register holds one result; while the receiver stalls, writes are
// still taken, and a second interpolation waits at the end of its drain until
// the register is free.
// Reset clears control state and sets all sizes to 32; voxel contents are
// undefined until written, and no clearing pass is made.
`include "trilinear_voxel_interpolator_macros.svh"

module trilinear_voxel_interpolator import tvi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // voxel_addr, voxel_value, coord_x, coord_y, coord_z, one unused bit
  input  logic [79:0] s_axis_tdata_i,
  // func
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // floor_x/y/z, near_x/y/z, weight_x/y/z, blend, seven zero bits
  output logic [79:0] m_axis_tdata_o
);

  localparam int OUT_W = 6 * IDX_W + 3 * W_W + SAMPLE_W;

  tvi_state_e state_q, state_d;

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  logic accept, is_write, is_interp;
  logic mem_we, issue, out_load, last_corner;
  tvi_mac_ctl_t mac_ctl;

  logic [ADDR_W-1:0]          in_addr;
  logic signed [SAMPLE_W-1:0] in_value;
  logic signed [COORD_W-1:0]  in_cx, in_cy, in_cz;

  logic [IDX_W-1:0] fx_d, fy_d, fz_d, nx_d, ny_d, nz_d;
  logic [W_W-1:0]   wx_d, wy_d, wz_d;
  logic [IDX_W-1:0] fx_q, fy_q, fz_q, nx_q, ny_q, nz_q;
  logic [W_W-1:0]   wx_q, wy_q, wz_q;
  logic [SIZE_W-1:0]  sx_q;
  logic [PLANE_W-1:0] dz_q;

  logic [IDX_W-1:0]  cx, cy, cz;
  logic [ADDR_W-1:0] corner_addr, mem_addr;
  logic [W_W-1:0]    kx, ky, kz;
  logic signed [SAMPLE_W-1:0] rdata, blend;
  logic mac_busy;

  assign in_addr  = s_axis_tdata_i[ADDR_W-1:0];
  assign in_value = s_axis_tdata_i[30:15];
  assign in_cx    = s_axis_tdata_i[46:31];
  assign in_cy    = s_axis_tdata_i[62:47];
  assign in_cz    = s_axis_tdata_i[78:63];

  assign accept    = s_axis_tvalid_i & s_axis_tready_o;
  assign is_write  = accept & (s_axis_tuser_i[0] == FUNC_WRITE);
  assign is_interp = accept & (s_axis_tuser_i[0] == FUNC_INTERP);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_W'(AXIS_MAX);
      size_y_q <= SIZE_W'(AXIS_MAX);
      size_z_q <= SIZE_W'(AXIS_MAX);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tvi_axis_split u_split_x (.coord_i(in_cx), .size_i(size_x_q),
                            .floor_o(fx_d), .near_o(nx_d), .weight_o(wx_d));
  tvi_axis_split u_split_y (.coord_i(in_cy), .size_i(size_y_q),
                            .floor_o(fy_d), .near_o(ny_d), .weight_o(wy_d));
  tvi_axis_split u_split_z (.coord_i(in_cz), .size_i(size_z_q),
                            .floor_o(fz_d), .near_o(nz_d), .weight_o(wz_d));

  always_ff @(posedge clk_i) begin
    if (is_interp) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
      nx_q <= nx_d;
      ny_q <= ny_d;
      nz_q <= nz_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
      wz_q <= wz_d;
      sx_q <= eff_size(size_x_q);
      dz_q <= PLANE_W'(eff_size(size_x_q) * eff_size(size_y_q));
    end
  end

  // corner i: bit 0 steps x, bit 1 steps y, bit 2 steps z
  always_comb begin
    cx = fx_q + IDX_W'(cnt_q[0]);
    cy = fy_q + IDX_W'(cnt_q[1]);
    cz = fz_q + IDX_W'(cnt_q[2]);
    corner_addr = ADDR_W'(cx) + ADDR_W'(cy * sx_q) + ADDR_W'(cz * dz_q);
    kx = cnt_q[0] ? wx_q : ONE_W - wx_q;
    ky = cnt_q[1] ? wy_q : ONE_W - wy_q;
    kz = cnt_q[2] ? wz_q : ONE_W - wz_q;
  end

  assign mem_addr = mem_we ? in_addr : corner_addr;

  tvi_voxel_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_value),
    .rdata_o (rdata)
  );

  assign mac_ctl.start = is_interp;
  assign mac_ctl.valid = issue;

  tvi_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .kx_i     (kx),
    .ky_i     (ky),
    .kz_i     (kz),
    .sample_i (rdata),
    .busy_o   (mac_busy),
    .blend_o  (blend)
  );

  assign last_corner = (cnt_q == CNT_W'(CORNERS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (is_interp) state_d = ST_ISSUE;
      ST_ISSUE: if (last_corner) state_d = ST_DRAIN;
      ST_DRAIN: if (!mac_busy && (!out_valid_q || m_axis_tready_i)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    issue           = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mem_we          = is_write;
      end
      ST_ISSUE: issue = 1'b1;
      ST_DRAIN: out_load = !mac_busy && (!out_valid_q || m_axis_tready_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {blend, wz_q, wy_q, wx_q, nz_q, ny_q, nx_q, fz_q, fy_q, fx_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(80 - OUT_W)'(0), out_data_q};

  `TVI_ASSERT_NEVER(a_no_write_busy, (state_q != ST_IDLE) && mem_we, "voxel write during interpolation")
  `TVI_ASSERT(a_load_free, out_load |-> (!out_valid_q || m_axis_tready_i), "result overwritten")
  `TVI_ASSERT(a_issue_end, (state_q == ST_ISSUE) && last_corner |=> (state_q == ST_DRAIN) && mac_busy, "corner sweep did not end in drain")
  `TVI_ASSERT(a_full_weight, out_valid_q && (out_data_q[38:30] == ONE_W) |-> (out_data_q[19:15] == out_data_q[4:0] + IDX_W'(1)), "x weight of one without near above floor")

endmodule

FILE: dv/trilinear_voxel_interpolator_tb.sv
`timescale 1ns / 1ps

module trilinear_voxel_interpolator_tb;
  import tvi_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 106;
  localparam int DRAIN_CYCLES     = 20;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int HOLD_PHASE       = 3;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int STORE_DEPTH      = 32768;

  // raw values written to size_x, size_y, size_z; 0, 1, 33 and 63 are out of range
  localparam int PHASE_SIZES [NUM_PHASES][3] = '{
    '{2, 2, 2}, '{32, 2, 3}, '{1, 32, 2}, '{33, 3, 2},
    '{11, 5, 3}, '{0, 13, 7}, '{63, 3, 1}
  };
  localparam logic [1:0] SIZE_REG_IDX [3] = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};

  typedef struct packed {
    logic        pad;
    logic [15:0] coord_z;
    logic [15:0] coord_y;
    logic [15:0] coord_x;
    logic [15:0] voxel_value;
    logic [14:0] voxel_addr;
  } voxel_beat_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] blend;
    logic [8:0]  weight_z;
    logic [8:0]  weight_y;
    logic [8:0]  weight_x;
    logic [4:0]  near_z;
    logic [4:0]  near_y;
    logic [4:0]  near_x;
    logic [4:0]  floor_z;
    logic [4:0]  floor_y;
    logic [4:0]  floor_x;
  } interp_result_t;

  class voxel_scoreboard;
    logic [15:0]    voxel_mem [STORE_DEPTH];
    logic [5:0]     size_reg [3];
    interp_result_t pending_q [$];
    int             errors;

    function new();
      foreach (size_reg[i]) size_reg[i] = 6'd32;
      errors = 0;
    endfunction

    function int clamp_size(logic [5:0] s);
      if (s < 6'd2) return 2;
      if (s > 6'(AXIS_MAX)) return AXIS_MAX;
      return int'(s);
    endfunction

    // floor, rounded index and upper weight along one axis
    function void split_axis(input logic [15:0] c, input int len,
                             output logic [4:0] fl, output logic [4:0] nr,
                             output logic [8:0] w);
      int whole;
      int last_idx;
      whole = int'($signed(c));
      whole = whole >>> 8;
      last_idx = len - 1;
      if (whole < 0) begin
        fl = '0;
        nr = '0;
        w  = '0;
      end else if (whole >= last_idx) begin
        fl = 5'(last_idx - 1);
        nr = 5'(last_idx);
        w  = 9'd256;
      end else begin
        fl = 5'(whole);
        nr = 5'(whole + ((c[7:0] >= 8'd128) ? 1 : 0));
        w  = {1'b0, c[7:0]};
      end
    endfunction

    function void note_input(logic f, voxel_beat_t b);
      int lx, ly, lz, base, a, kx, ky, kz;
      longint acc;
      interp_result_t r;
      if (f == FUNC_WRITE) begin
        voxel_mem[b.voxel_addr] = b.voxel_value;
        return;
      end
      lx = clamp_size(size_reg[0]);
      ly = clamp_size(size_reg[1]);
      lz = clamp_size(size_reg[2]);
      r = '0;
      split_axis(b.coord_x, lx, r.floor_x, r.near_x, r.weight_x);
      split_axis(b.coord_y, ly, r.floor_y, r.near_y, r.weight_y);
      split_axis(b.coord_z, lz, r.floor_z, r.near_z, r.weight_z);
      base = int'(r.floor_x) + int'(r.floor_y) * lx + int'(r.floor_z) * lx * ly;
      acc = 0;
      for (int i = 0; i < 8; i++) begin
        kx = (i & 1) ? int'(r.weight_x) : 256 - int'(r.weight_x);
        ky = ((i >> 1) & 1) ? int'(r.weight_y) : 256 - int'(r.weight_y);
        kz = ((i >> 2) & 1) ? int'(r.weight_z) : 256 - int'(r.weight_z);
        a = base + (i & 1) + ((i >> 1) & 1) * lx + ((i >> 2) & 1) * lx * ly;
        acc += longint'(kx * ky * kz) * longint'($signed(voxel_mem[a]));
      end
      // halves go towards plus infinity
      acc = (acc + (longint'(1) <<< 23)) >>> 24;
      r.blend = acc[15:0];
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(interp_result_t got);
      interp_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("output beat with no interpolation pending");
        return;
      end
      want = pending_q.pop_front();
      check_field("floor_x", got.floor_x, want.floor_x);
      check_field("floor_y", got.floor_y, want.floor_y);
      check_field("floor_z", got.floor_z, want.floor_z);
      check_field("near_x", got.near_x, want.near_x);
      check_field("near_y", got.near_y, want.near_y);
      check_field("near_z", got.near_z, want.near_z);
      check_field("weight_x", got.weight_x, want.weight_x);
      check_field("weight_y", got.weight_y, want.weight_y);
      check_field("weight_z", got.weight_z, want.weight_z);
      check_field("blend", got.blend, want.blend);
      check_field("pad", got.pad, want.pad);
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  logic [1:0]     cfg_idx;
  logic [5:0]     cfg_wdata;
  logic           s_tvalid;
  logic           s_tready;
  voxel_beat_t    s_tdata;
  logic [0:0]     s_tuser;
  logic           m_tvalid;
  logic           m_tready;
  logic [79:0]    m_tdata;

  voxel_scoreboard sb = new();
  bit              voxel_seen [STORE_DEPTH];
  int              eff_len [3];
  bit              idle_on;
  int              phase_no;
  int              quiet_cycles;

  trilinear_voxel_interpolator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
    if (rst_n && m_tvalid && m_tready) sb.check_result(interp_result_t'(m_tdata));
  end

  // nothing accepted on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // output side; one long hold-off so that the block backs up its input
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && phase_no == HOLD_PHASE && sb.pending_q.size() != 0) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      m_tready <= !(idle_on && $urandom_range(0, 99) < 30);
    end
  end

  task automatic send_beat(input logic f, input voxel_beat_t b);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser[0] <= f;
    s_tdata    <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_write(input int addr, input int val);
    voxel_beat_t b;
    b             = '0;
    b.voxel_addr  = addr[14:0];
    b.voxel_value = val[15:0];
    // coordinates are don't-care on a write
    b.coord_x     = 16'($urandom);
    b.coord_y     = 16'($urandom);
    b.coord_z     = 16'($urandom);
    voxel_seen[addr[14:0]] = 1'b1;
    send_beat(FUNC_WRITE, b);
  endtask

  task automatic send_interp(input int cx, input int cy, input int cz);
    voxel_beat_t b;
    b             = '0;
    b.voxel_addr  = 15'($urandom);
    b.voxel_value = 16'($urandom);
    b.coord_x     = cx[15:0];
    b.coord_y     = cy[15:0];
    b.coord_z     = cz[15:0];
    send_beat(FUNC_INTERP, b);
  endtask

  function automatic int random_sample();
    if ($urandom_range(0, 9) < 2) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int random_coord(input int len);
    int pick;
    int frac;
    pick = $urandom_range(0, 9);
    if (pick < 6) return int'($urandom_range(0, (len + 2) * 256)) - 256;
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: frac = 0;
        1: frac = 127;
        2: frac = 128;
        default: frac = 255;
      endcase
      return (int'($urandom_range(0, len + 1)) - 1) * 256 + frac;
    end
    return int'($urandom_range(0, 65535));
  endfunction

  // sizes may only change once every pending interpolation has come out
  task automatic drain_block();
    s_tvalid <= 1'b0;
    // let the sampler note the last accepted beat first
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(input int sx, input int sy, input int sz);
    int raw [3];
    raw = '{sx, sy, sz};
    cfg_we <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_idx   <= SIZE_REG_IDX[i];
      cfg_wdata <= raw[i][5:0];
      @(posedge clk);
      sb.size_reg[i] = raw[i][5:0];
      eff_len[i] = sb.clamp_size(raw[i][5:0]);
    end
    cfg_we <= 1'b0;
  endtask

  // every voxel of the current volume is written before any corner read
  task automatic fill_volume();
    int total;
    total = eff_len[0] * eff_len[1] * eff_len[2];
    for (int a = 0; a < total; a++)
      if (!voxel_seen[a]) send_write(a, random_sample());
  endtask

  task automatic run_directed();
    int corner_vals [8];
    corner_vals = '{-32768, 32767, 0, -1, 1, 12345, -20000, 255};
    for (int a = 0; a < 8; a++) send_write(a, corner_vals[a]);
    send_interp(0, 0, 0);
    send_interp(-1, -1, -1);
    send_interp(-32768, -32768, -32768);
    send_interp(32767, 32767, 32767);
    send_interp(128, 128, 128);
    send_interp(127, 127, 127);
    send_interp(256, 256, 256);
    send_interp(255, 255, 255);
    send_interp(64, 192, 128);
    send_interp(128, 0, 0);
    // exact halves below zero round up
    send_write(0, -1);
    send_write(1, 0);
    send_interp(128, 0, 0);
    send_write(0, -3);
    send_interp(128, 0, 0);
  endtask

  task automatic send_random_item();
    int total;
    total = eff_len[0] * eff_len[1] * eff_len[2];
    if ($urandom_range(0, 99) < 60)
      send_interp(random_coord(eff_len[0]), random_coord(eff_len[1]),
                  random_coord(eff_len[2]));
    else if ($urandom_range(0, 1) != 0)
      send_write($urandom_range(0, total - 1), random_sample());
    else
      send_write($urandom_range(0, STORE_DEPTH - 1), random_sample());
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_SIZE_X;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FUNC_WRITE;
    idle_on      = 1'b1;
    phase_no     = 0;
    quiet_cycles = 0;
    foreach (eff_len[i]) eff_len[i] = AXIS_MAX;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      phase_no = p;
      // one phase runs flat out on both sides
      idle_on  = (p != 2);
      write_sizes(PHASE_SIZES[p][0], PHASE_SIZES[p][1], PHASE_SIZES[p][2]);
      fill_volume();
      if (p == 0) run_directed();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_item();
    end
    drain_block();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/tvi_pkg.sv
sv/tvi_axis_split.sv
sv/tvi_voxel_mem.sv
sv/tvi_mac.sv
sv/trilinear_voxel_interpolator.sv
dv/trilinear_voxel_interpolator_tb.sv
